// File: sv/pvfb_pkg.sv
// shared types and constants for the point voxel feature binning unit
// no dependencies; used by point_voxel_feature_binning_unit, pvfb_checker and the testbench
package pvfb_pkg;

   localparam int VOXELS    = 16384;
   localparam int IDX_W     = 14;
   localparam int COORD_W   = 18;
   localparam int CNT_W     = 18;
   localparam int SUM_W     = 36;
   localparam int SIZE_W    = 16;
   localparam int GRID_W    = 12;
   localparam int COUNT_CAP = 131072;
   localparam int WORD_W    = CNT_W + 3 * SUM_W;
   localparam int RSP_W     = 200;

   typedef enum logic [1:0] {
      KIND_ACCUM = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_SIZE_X   = 3'd3,
      CSR_SIZE_Y   = 3'd4,
      CSR_SIZE_Z   = 3'd5,
      CSR_GRID     = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_AXIS_LOAD,
      ST_AXIS_RUN,
      ST_INDEX_MUL,
      ST_INDEX_MUL2,
      ST_INDEX_SUM,
      ST_READ,
      ST_RDATA,
      ST_CEN_LOAD,
      ST_CEN_RUN,
      ST_OUT
   } state_type;

endpackage

// File: sv/point_voxel_feature_binning_unit.sv
// Accumulate: req_tready is low from the transfer until the voxel update is written, so
// the next item waits on three axis divisions, the index sum and the memory read. Query:
// the result also waits on three centroid divisions and a free output register. One shared
// restoring divider does all divisions, one quotient bit per cycle (18 bits per axis for
// binning, 36 bits per axis for the centroid). Reset and a clear item sweep the voxel
// memory one entry per cycle, with req_tready low; csr writes are taken at all times. Reset is synchronous.
// depends on pvfb_pkg
module point_voxel_feature_binning_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,   // point_x, point_y, point_z, point_valid, zero pad
   input  logic [1:0]   req_tuser,   // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // cell_index, cell_population, centroid_x/y/z, local_x/y/z, center_offset_x/y/z
   output logic [199:0] rsp_tdata,
   output logic         rsp_tuser,   // padded
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [35:0]  csr_data
);

   // configuration
   logic signed [17:0] org_ff [3];
   logic [15:0]        size_ff [3];
   logic [11:0]        grid_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0]  <= -18'sd35840;
         org_ff[1]  <= -18'sd20480;
         org_ff[2]  <= -18'sd10240;
         size_ff[0] <= 16'd512;
         size_ff[1] <= 16'd512;
         size_ff[2] <= 16'd20480;
         grid_ff[0] <= 12'd140;
         grid_ff[1] <= 12'd80;
         grid_ff[2] <= 12'd1;
      end else if (csr_valid) begin
         unique case (pvfb_pkg::csr_index_type'(csr_index))
            pvfb_pkg::CSR_ORIGIN_X: org_ff[0]  <= csr_data[17:0];
            pvfb_pkg::CSR_ORIGIN_Y: org_ff[1]  <= csr_data[17:0];
            pvfb_pkg::CSR_ORIGIN_Z: org_ff[2]  <= csr_data[17:0];
            pvfb_pkg::CSR_SIZE_X:   size_ff[0] <= csr_data[15:0];
            pvfb_pkg::CSR_SIZE_Y:   size_ff[1] <= csr_data[15:0];
            pvfb_pkg::CSR_SIZE_Z:   size_ff[2] <= csr_data[15:0];
            pvfb_pkg::CSR_GRID: begin
               grid_ff[0] <= csr_data[11:0];
               grid_ff[1] <= csr_data[23:12];
               grid_ff[2] <= csr_data[35:24];
            end
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // control and datapath registers
   pvfb_pkg::state_type state_ff, state_in;
   logic [1:0]          axis_ff, axis_in;
   logic                query_ff, query_in;
   logic                pvalid_ff, pvalid_in;
   logic                inside_ff, inside_in;
   logic [13:0]         clr_addr_ff, clr_addr_in;

   logic signed [17:0]  p_ff [3], p_in [3];
   logic signed [18:0]  s_ff [3], s_in [3];
   logic [11:0]         c_ff [3], c_in [3];
   logic [15:0]         rem_ff [3], rem_in [3];
   logic signed [17:0]  cen_ff [3], cen_in [3];
   logic signed [35:0]  sum_ff [3], sum_in [3];
   logic [17:0]         cnt_ff, cnt_in;

   logic [23:0]         mul_a_ff, mul_a_in;
   logic [23:0]         mul_b_ff, mul_b_in;
   logic [35:0]         mul_c_ff, mul_c_in;
   logic [13:0]         idx_ff, idx_in;

   // shared restoring divider
   logic [35:0]         div_num_ff, div_num_in;
   logic [17:0]         div_den_ff, div_den_in;
   logic [17:0]         div_rem_ff, div_rem_in;
   logic [5:0]          div_step_ff, div_step_in;
   logic                div_neg_ff, div_neg_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [199:0]        rsp_data_ff, rsp_data_in;
   logic                rsp_pad_ff, rsp_pad_in;

   // voxel memory: {count, sum_x, sum_y, sum_z}
   logic [pvfb_pkg::WORD_W-1:0] mem [pvfb_pkg::VOXELS];
   logic [pvfb_pkg::WORD_W-1:0] mem_rdata_ff;
   logic                        mem_we;
   logic [13:0]                 mem_waddr;
   logic [pvfb_pkg::WORD_W-1:0] mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[idx_ff];
   end

   // divider step
   logic [18:0] div_trial;
   logic        div_ge;
   logic [17:0] div_rem_next;

   always_comb begin
      div_trial    = {div_rem_ff, div_num_ff[35]};
      div_ge       = div_trial >= {1'b0, div_den_ff};
      div_rem_next = div_ge ? 18'(div_trial - {1'b0, div_den_ff}) : div_trial[17:0];
   end

   assign req_tready = (state_ff == pvfb_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_pad_ff;

   logic signed [18:0] s_new;
   logic [17:0]        q18;
   logic [36:0]        idx_total;
   logic [35:0]        sum_mag;
   logic signed [18:0] local_v [3];
   logic signed [19:0] off_base [3];
   logic signed [19:0] off_full [3];
   logic signed [18:0] off_sat [3];
   logic [16:0]        half [3];

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      query_in     = query_ff;
      pvalid_in    = pvalid_ff;
      inside_in    = inside_ff;
      clr_addr_in  = clr_addr_ff;
      p_in         = p_ff;
      s_in         = s_ff;
      c_in         = c_ff;
      rem_in       = rem_ff;
      cen_in       = cen_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_c_in     = mul_c_ff;
      idx_in       = idx_ff;
      div_num_in   = div_num_ff;
      div_den_in   = div_den_ff;
      div_rem_in   = div_rem_ff;
      div_step_in  = div_step_ff;
      div_neg_in   = div_neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_pad_in   = rsp_pad_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_addr_ff;
      mem_wdata    = '0;

      s_new     = 19'({p_ff[axis_ff][17], p_ff[axis_ff]} - {org_ff[axis_ff][17], org_ff[axis_ff]});
      q18       = div_num_ff[17:0];
      idx_total = {25'd0, c_ff[0]} + {13'd0, mul_a_ff} + {1'b0, mul_c_ff};
      sum_mag   = sum_ff[axis_ff][35] ? 36'(-sum_ff[axis_ff]) : 36'(sum_ff[axis_ff]);

      for (int a = 0; a < 3; a++) begin
         local_v[a]  = 19'({p_ff[a][17], p_ff[a]} - {cen_ff[a][17], cen_ff[a]});
         half[a]     = 17'(({1'b0, size_ff[a]} + 17'd1) >> 1);
         off_base[a] = inside_ff ? $signed({4'd0, rem_ff[a]}) : $signed({s_ff[a][18], s_ff[a]});
         off_full[a] = 20'(off_base[a] - $signed({3'd0, half[a]}));
         if (off_full[a] < -20'sd262144) begin
            off_sat[a] = -19'sd262144;
         end else if (off_full[a] > 20'sd262143) begin
            off_sat[a] = 19'sd262143;
         end else begin
            off_sat[a] = off_full[a][18:0];
         end
      end

      unique case (state_ff)
         pvfb_pkg::ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 14'd1;
            if (clr_addr_ff == '1) begin
               state_in = pvfb_pkg::ST_IDLE;
            end
         end
         pvfb_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               unique case (pvfb_pkg::kind_type'(req_tuser))
                  pvfb_pkg::KIND_ACCUM, pvfb_pkg::KIND_QUERY: begin
                     p_in[0]   = req_tdata[17:0];
                     p_in[1]   = req_tdata[35:18];
                     p_in[2]   = req_tdata[53:36];
                     pvalid_in = req_tdata[54];
                     query_in  = (req_tuser == pvfb_pkg::KIND_QUERY);
                     inside_in = 1'b1;
                     axis_in   = 2'd0;
                     state_in  = pvfb_pkg::ST_AXIS_LOAD;
                  end
                  pvfb_pkg::KIND_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = pvfb_pkg::ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         pvfb_pkg::ST_AXIS_LOAD: begin
            s_in[axis_ff] = s_new;
            div_num_in    = {s_new[17:0], 18'd0};
            div_den_in    = {2'd0, size_ff[axis_ff]};
            div_rem_in    = '0;
            div_step_in   = 6'd18;
            state_in      = pvfb_pkg::ST_AXIS_RUN;
         end
         pvfb_pkg::ST_AXIS_RUN: begin
            if (div_step_ff != '0) begin
               div_num_in  = {div_num_ff[34:0], div_ge};
               div_rem_in  = div_rem_next;
               div_step_in = div_step_ff - 6'd1;
            end else begin
               // negative offset, zero size or past the grid is outside
               if (s_ff[axis_ff][18] || size_ff[axis_ff] == '0
                   || q18 >= {6'd0, grid_ff[axis_ff]}) begin
                  inside_in = 1'b0;
               end
               c_in[axis_ff]   = q18[11:0];
               rem_in[axis_ff] = div_rem_ff[15:0];
               if (axis_ff == 2'd2) begin
                  state_in = pvfb_pkg::ST_INDEX_MUL;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = pvfb_pkg::ST_AXIS_LOAD;
               end
            end
         end
         pvfb_pkg::ST_INDEX_MUL: begin
            mul_a_in = grid_ff[0] * c_ff[1];
            mul_b_in = grid_ff[0] * grid_ff[1];
            state_in = pvfb_pkg::ST_INDEX_MUL2;
         end
         pvfb_pkg::ST_INDEX_MUL2: begin
            mul_c_in = mul_b_ff * c_ff[2];
            state_in = pvfb_pkg::ST_INDEX_SUM;
         end
         pvfb_pkg::ST_INDEX_SUM: begin
            inside_in = inside_ff && pvalid_ff && (idx_total < 37'(pvfb_pkg::VOXELS));
            idx_in    = (inside_ff && pvalid_ff && (idx_total < 37'(pvfb_pkg::VOXELS)))
                        ? idx_total[13:0] : '0;
            state_in  = pvfb_pkg::ST_READ;
         end
         pvfb_pkg::ST_READ: begin
            state_in = pvfb_pkg::ST_RDATA;
         end
         pvfb_pkg::ST_RDATA: begin
            cnt_in    = mem_rdata_ff[125:108];
            sum_in[0] = mem_rdata_ff[107:72];
            sum_in[1] = mem_rdata_ff[71:36];
            sum_in[2] = mem_rdata_ff[35:0];
            if (query_ff) begin
               axis_in  = 2'd0;
               state_in = pvfb_pkg::ST_CEN_LOAD;
            end else begin
               if (mem_rdata_ff[125:108] < 18'(pvfb_pkg::COUNT_CAP)) begin
                  mem_we    = 1'b1;
                  mem_waddr = idx_ff;
                  mem_wdata = {18'(mem_rdata_ff[125:108] + 18'd1),
                               36'(mem_rdata_ff[107:72] + {{18{p_ff[0][17]}}, p_ff[0]}),
                               36'(mem_rdata_ff[71:36] + {{18{p_ff[1][17]}}, p_ff[1]}),
                               36'(mem_rdata_ff[35:0] + {{18{p_ff[2][17]}}, p_ff[2]})};
               end
               state_in = pvfb_pkg::ST_IDLE;
            end
         end
         pvfb_pkg::ST_CEN_LOAD: begin
            div_num_in  = sum_mag;
            div_den_in  = cnt_ff;
            div_rem_in  = '0;
            div_neg_in  = sum_ff[axis_ff][35];
            div_step_in = 6'd36;
            state_in    = pvfb_pkg::ST_CEN_RUN;
         end
         pvfb_pkg::ST_CEN_RUN: begin
            if (div_step_ff != '0) begin
               div_num_in  = {div_num_ff[34:0], div_ge};
               div_rem_in  = div_rem_next;
               div_step_in = div_step_ff - 6'd1;
            end else begin
               if (cnt_ff == '0) begin
                  cen_in[axis_ff] = '0;
               end else begin
                  cen_in[axis_ff] = div_neg_ff ? 18'(-q18) : q18;
               end
               if (axis_ff == 2'd2) begin
                  state_in = pvfb_pkg::ST_OUT;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = pvfb_pkg::ST_CEN_LOAD;
               end
            end
         end
         pvfb_pkg::ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pad_in   = !inside_ff;
               rsp_data_in  = {off_sat[2], off_sat[1], off_sat[0],
                               local_v[2], local_v[1], local_v[0],
                               cen_ff[2], cen_ff[1], cen_ff[0],
                               cnt_ff, idx_ff};
               state_in     = pvfb_pkg::ST_IDLE;
            end
         end
         default: state_in = pvfb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pvfb_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         div_step_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         div_step_ff  <= div_step_in;
         rsp_valid_ff <= rsp_valid_in;
         axis_ff      <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff    <= query_in;
      pvalid_ff   <= pvalid_in;
      inside_ff   <= inside_in;
      p_ff        <= p_in;
      s_ff        <= s_in;
      c_ff        <= c_in;
      rem_ff      <= rem_in;
      cen_ff      <= cen_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      mul_c_ff    <= mul_c_in;
      idx_ff      <= idx_in;
      div_num_ff  <= div_num_in;
      div_den_ff  <= div_den_in;
      div_rem_ff  <= div_rem_in;
      div_neg_ff  <= div_neg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_pad_ff  <= rsp_pad_in;
   end

   // a stored count never passes the cap
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> mem_wdata[125:108] <= 18'(pvfb_pkg::COUNT_CAP))
      else $error("voxel count above cap");

   // a padded result always points at voxel 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[13:0] == '0)
      else $error("padded result with nonzero index");

   // an empty voxel has a zero centroid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31:14] == '0 |-> rsp_tdata[85:32] == '0)
      else $error("empty voxel with nonzero centroid");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser != pvfb_pkg::KIND_NONE |=> !req_tready)
      else $error("second item taken while busy");

endmodule

// File: tb/pvfb_checker.sv
// checker for the point voxel feature binning unit: watches the csr, point and feature
// channels, predicts voxel features from its own copy of the store, compares results
// depends on pvfb_pkg
module pvfb_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [55:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [199:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [35:0]  csr_data,
   output int           fails,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // same layout as rsp_tdata, msb first
   typedef struct packed {
      logic signed [18:0] off_z;
      logic signed [18:0] off_y;
      logic signed [18:0] off_x;
      logic signed [18:0] loc_z;
      logic signed [18:0] loc_y;
      logic signed [18:0] loc_x;
      logic signed [17:0] cen_z;
      logic signed [17:0] cen_y;
      logic signed [17:0] cen_x;
      logic [17:0]        pop;
      logic [13:0]        idx;
   } features_type;

   typedef struct packed {
      features_type feat;
      logic         pad;
   } voxel_result_type;

   voxel_result_type feature_q[$];

   logic signed [17:0] org_reg[3];
   logic [15:0]        size_reg[3];
   logic [35:0]        grid_reg;

   int     pop_store[pvfb_pkg::VOXELS];
   longint sum_store[3][pvfb_pkg::VOXELS];

   function automatic longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint clamp19(longint v);
      if (v < -262144) return -262144;
      if (v > 262143) return 262143;
      return v;
   endfunction

   task automatic empty_store();
      for (int i = 0; i < pvfb_pkg::VOXELS; i++) begin
         pop_store[i] = 0;
         sum_store[0][i] = 0;
         sum_store[1][i] = 0;
         sum_store[2][i] = 0;
      end
   endtask

   task automatic bin_point(pvfb_pkg::kind_type kind, logic [55:0] d);
      longint           p[3], sz[3], g[3], s[3], c[3], cen[3];
      longint           idx, cnt, twice;
      bit               in_grid;
      voxel_result_type r;
      in_grid = 1;
      idx = 0;
      for (int a = 0; a < 3; a++) begin
         p[a] = longint'($signed(d[a*18 +: 18]));
         sz[a] = longint'(size_reg[a]);
         g[a] = longint'(grid_reg[a*12 +: 12]);
         s[a] = p[a] - longint'(org_reg[a]);
         c[a] = 0;
         if (sz[a] == 0) in_grid = 0;
         else begin
            c[a] = floor_quot(s[a], sz[a]);
            if (c[a] < 0 || c[a] >= g[a]) begin
               in_grid = 0;
               c[a] = 0;
            end
         end
      end
      if (in_grid) begin
         idx = c[0] + g[0] * c[1] + g[0] * g[1] * c[2];
         if (idx >= pvfb_pkg::VOXELS) in_grid = 0;
      end
      if (!d[54]) in_grid = 0;
      if (!in_grid) begin
         c[0] = 0; c[1] = 0; c[2] = 0;
         idx = 0;
      end
      if (kind == pvfb_pkg::KIND_ACCUM) begin
         if (pop_store[idx] < pvfb_pkg::COUNT_CAP) begin
            pop_store[idx]++;
            for (int a = 0; a < 3; a++) sum_store[a][idx] += p[a];
         end
         return;
      end
      cnt = pop_store[idx];
      for (int a = 0; a < 3; a++) cen[a] = (cnt != 0) ? sum_store[a][idx] / cnt : 0;
      r.pad = !in_grid;
      r.feat.idx = idx[13:0];
      r.feat.pop = cnt[17:0];
      r.feat.cen_x = cen[0][17:0];
      r.feat.cen_y = cen[1][17:0];
      r.feat.cen_z = cen[2][17:0];
      r.feat.loc_x = 19'(p[0] - cen[0]);
      r.feat.loc_y = 19'(p[1] - cen[1]);
      r.feat.loc_z = 19'(p[2] - cen[2]);
      twice = 2 * (s[0] - c[0] * sz[0]) - sz[0];
      r.feat.off_x = 19'(clamp19(floor_quot(twice, 2)));
      twice = 2 * (s[1] - c[1] * sz[1]) - sz[1];
      r.feat.off_y = 19'(clamp19(floor_quot(twice, 2)));
      twice = 2 * (s[2] - c[2] * sz[2]) - sz[2];
      r.feat.off_z = 19'(clamp19(floor_quot(twice, 2)));
      feature_q.insert(feature_q.size(), r);
   endtask

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   task automatic compare_result();
      voxel_result_type w;
      features_type     g;
      if (feature_q.size() == 0) begin
         $error("feature transfer with no query waiting");
         fails++;
         return;
      end
      w = feature_q.pop_front();
      g = rsp_tdata;
      check_field("cell_index", w.feat.idx, g.idx);
      check_field("cell_population", w.feat.pop, g.pop);
      check_field("padded", w.pad, rsp_tuser);
      check_field("centroid_x", w.feat.cen_x, g.cen_x);
      check_field("centroid_y", w.feat.cen_y, g.cen_y);
      check_field("centroid_z", w.feat.cen_z, g.cen_z);
      check_field("local_x", w.feat.loc_x, g.loc_x);
      check_field("local_y", w.feat.loc_y, g.loc_y);
      check_field("local_z", w.feat.loc_z, g.loc_z);
      check_field("center_offset_x", w.feat.off_x, g.off_x);
      check_field("center_offset_y", w.feat.off_y, g.off_y);
      check_field("center_offset_z", w.feat.off_z, g.off_z);
   endtask

   initial begin
      fails = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         org_reg[0] = -18'sd35840;
         org_reg[1] = -18'sd20480;
         org_reg[2] = -18'sd10240;
         size_reg[0] = 16'd512;
         size_reg[1] = 16'd512;
         size_reg[2] = 16'd20480;
         grid_reg = 36'd17105036;
         empty_store();
         feature_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_result();
         if (req_tvalid && req_tready) begin
            case (pvfb_pkg::kind_type'(req_tuser))
               pvfb_pkg::KIND_CLEAR: empty_store();
               pvfb_pkg::KIND_ACCUM, pvfb_pkg::KIND_QUERY:
                  bin_point(pvfb_pkg::kind_type'(req_tuser), req_tdata);
               default: ;
            endcase
         end
         if (csr_valid && csr_ready) begin
            case (pvfb_pkg::csr_index_type'(csr_index))
               pvfb_pkg::CSR_ORIGIN_X: org_reg[0] = csr_data[17:0];
               pvfb_pkg::CSR_ORIGIN_Y: org_reg[1] = csr_data[17:0];
               pvfb_pkg::CSR_ORIGIN_Z: org_reg[2] = csr_data[17:0];
               pvfb_pkg::CSR_SIZE_X:   size_reg[0] = csr_data[15:0];
               pvfb_pkg::CSR_SIZE_Y:   size_reg[1] = csr_data[15:0];
               pvfb_pkg::CSR_SIZE_Z:   size_reg[2] = csr_data[15:0];
               pvfb_pkg::CSR_GRID:     grid_reg = csr_data;
               default: ;
            endcase
         end
      end
      pending = feature_q.size();
   end

endmodule

// File: tb/tb_point_voxel_feature_binning_unit.sv
// top of the point voxel feature binning testbench: clock, reset, csr phases and point
// stimulus; depends on pvfb_pkg, point_voxel_feature_binning_unit and pvfb_checker
module tb_point_voxel_feature_binning_unit;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [55:0]  req_tdata = '0;
   logic [1:0]   req_tuser = pvfb_pkg::KIND_NONE;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [199:0] rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [2:0]   csr_index = pvfb_pkg::CSR_ORIGIN_X;
   logic [35:0]  csr_data = '0;
   int           fails;
   int           pending;

   bit  calm = 0;
   int  rsp_hold = 0;

   // current grid, mirrored for point generation
   longint org[3], sz[3], g[3];
   logic [53:0] seen_q[$];

   point_voxel_feature_binning_unit uut (.*);

   pvfb_checker chk (.*);

   initial forever #5 clock = ~clock;

   // result side stalls: a fresh draw after every result transfer
   always @(posedge clock)
      if (rsp_tvalid && rsp_tready) rsp_hold = calm ? 0 : $urandom_range(0, 4);

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 0;
      end else rsp_tready <= 1;
   end

   task automatic send(pvfb_pkg::kind_type kind, longint x, longint y, longint z, bit v);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {1'b0, v, z[17:0], y[17:0], x[17:0]};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic program_grid(longint ox, longint oy, longint oz,
                               longint sx, longint sy, longint sz_z,
                               longint gx, longint gy, longint gz);
      logic [35:0] vals[7];
      // idle first: no query left open, then a wait long enough for accumulates to finish
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      vals[0] = 36'(ox); vals[1] = 36'(oy); vals[2] = 36'(oz);
      vals[3] = 36'(sx); vals[4] = 36'(sy); vals[5] = 36'(sz_z);
      vals[6] = {gz[11:0], gy[11:0], gx[11:0]};
      org[0] = ox; org[1] = oy; org[2] = oz;
      sz[0] = sx; sz[1] = sy; sz[2] = sz_z;
      g[0] = gx; g[1] = gy; g[2] = gz;
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1;
         csr_index <= pvfb_pkg::csr_index_type'(i);
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 0;
      seen_q.delete();
   endtask

   function automatic longint near_grid(int a);
      longint v;
      v = org[a] + longint'($urandom_range(0, 32'(g[a] * sz[a] + sz[a]))) - sz[a] / 2;
      if (v < -131072) v = -131072;
      if (v > 131071) v = 131071;
      return v;
   endfunction

   function automatic longint any_coord();
      return longint'($signed(18'($urandom)));
   endfunction

   task automatic random_points(int n);
      int          r;
      logic [53:0] pt;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            pt = {18'(near_grid(2)), 18'(near_grid(1)), 18'(near_grid(0))};
            seen_q.insert(seen_q.size(), pt);
            send(pvfb_pkg::KIND_ACCUM, $signed(pt[17:0]), $signed(pt[35:18]),
                 $signed(pt[53:36]), 1);
         end else if (r < 80 && seen_q.size() > 0) begin
            pt = seen_q[$urandom_range(0, seen_q.size() - 1)];
            send(pvfb_pkg::KIND_QUERY, $signed(pt[17:0]), $signed(pt[35:18]),
                 $signed(pt[53:36]), 1);
         end else if (r < 87) begin
            send(pvfb_pkg::KIND_QUERY, near_grid(0), near_grid(1), near_grid(2), 1);
         end else if (r < 95) begin
            send(pvfb_pkg::kind_type'($urandom_range(0, 1)), any_coord(), any_coord(),
                 any_coord(), $urandom_range(0, 1));
         end else if (r < 98) begin
            send(pvfb_pkg::kind_type'($urandom_range(0, 1)), near_grid(0), near_grid(1),
                 near_grid(2), 0);
         end else if (r < 99) begin
            send(pvfb_pkg::KIND_CLEAR, any_coord(), any_coord(), any_coord(),
                 $urandom_range(0, 1));
            seen_q.delete();
         end else begin
            // ignored kind, does not count
            send(pvfb_pkg::KIND_NONE, any_coord(), any_coord(), any_coord(), 1);
            i--;
         end
      end
   endtask

   initial begin
      org[0] = -35840; org[1] = -20480; org[2] = -10240;
      sz[0] = 512; sz[1] = 512; sz[2] = 20480;
      g[0] = 140; g[1] = 80; g[2] = 1;
      repeat (5) @(negedge clock);
      reset <= 0;

      // reset grid: a real point twice, mask, both coordinate extremes into voxel 0
      send(pvfb_pkg::KIND_ACCUM, 0, 0, 0, 1);
      send(pvfb_pkg::KIND_ACCUM, 100, -100, 50, 1);
      send(pvfb_pkg::KIND_QUERY, 0, 0, 0, 1);
      send(pvfb_pkg::KIND_QUERY, 0, 0, 0, 0);
      send(pvfb_pkg::KIND_ACCUM, -131072, -131072, -131072, 1);
      send(pvfb_pkg::KIND_ACCUM, 131071, 131071, 131071, 0);
      send(pvfb_pkg::KIND_QUERY, 131071, -131072, 131071, 1);
      send(pvfb_pkg::KIND_NONE, 5, 5, 5, 1);
      send(pvfb_pkg::KIND_QUERY, -35840, -20480, -10240, 1);
      send(pvfb_pkg::KIND_CLEAR, 0, 0, 0, 1);
      send(pvfb_pkg::KIND_QUERY, 0, 0, 0, 1);

      // widest grid: index runs past the store
      program_grid(-131072, -131072, -131072, 65535, 65535, 65535, 4095, 4095, 4095);
      send(pvfb_pkg::KIND_ACCUM, 131071, 131071, 131071, 1);
      send(pvfb_pkg::KIND_QUERY, 131071, 131071, 131071, 1);
      send(pvfb_pkg::KIND_ACCUM, -131072, -131072, -131072, 1);
      send(pvfb_pkg::KIND_QUERY, -131072, -131072, -131072, 1);

      // offset saturation for padded points, empty grid counts
      program_grid(131071, 131071, 131071, 1, 1, 1, 0, 0, 0);
      send(pvfb_pkg::KIND_QUERY, -131072, 131071, -131072, 1);
      program_grid(131071, 131071, 131071, 65535, 65535, 65535, 1, 1, 1);
      send(pvfb_pkg::KIND_QUERY, -131072, -131072, -131072, 0);
      send(pvfb_pkg::KIND_ACCUM, 131071, 131071, 131071, 1);
      send(pvfb_pkg::KIND_QUERY, 131071, 131071, 131071, 1);

      // zero cell size on one axis
      program_grid(-1000, -1000, -1000, 0, 300, 300, 5, 5, 5);
      send(pvfb_pkg::KIND_ACCUM, 10, 10, 10, 1);
      send(pvfb_pkg::KIND_QUERY, 10, 10, 10, 1);
      random_points(60);

      for (int ph = 0; ph < 8; ph++) begin
         calm = (ph % 3 == 2);
         program_grid(longint'($urandom_range(0, 4000)) - 2000,
                      longint'($urandom_range(0, 4000)) - 2000,
                      longint'($urandom_range(0, 4000)) - 2000,
                      $urandom_range(1, 3000), $urandom_range(1, 3000),
                      $urandom_range(1, 3000),
                      $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6));
         random_points(135);
      end
      calm = 0;
      req_tvalid <= 0;

      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (fails == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
